### rtl/bsps_pkg.sv
// shared codes for the box strided point scanner
package bsps_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_LOW_X    = 3'd0,
    REG_BOX_LOW_Y    = 3'd1,
    REG_BOX_LOW_Z    = 3'd2,
    REG_BOX_HIGH_X   = 3'd3,
    REG_BOX_HIGH_Y   = 3'd4,
    REG_BOX_HIGH_Z   = 3'd5,
    REG_STRIDE_STEPS = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  // number of coordinates carried by the point, whatever the active dimensions
  localparam int unsigned NUM_COORDS = 3;

endpackage

### rtl/bsps_in_if.sv
// input and result channel interfaces of the box strided point scanner
interface bsps_in_if #(
  parameter int unsigned COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic signed [COORD_WIDTH-1:0] start_x;
  logic signed [COORD_WIDTH-1:0] start_y;
  logic signed [COORD_WIDTH-1:0] start_z;

  modport source (output valid, op, start_x, start_y, start_z, input ready);
  modport sink (input valid, op, start_x, start_y, start_z, output ready);
endinterface

interface bsps_out_if #(
  parameter int unsigned COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;
  logic                          outside_box;

  modport source (output valid, point_x, point_y, point_z, outside_box, input ready);
  modport sink (input valid, point_x, point_y, point_z, outside_box, output ready);
endinterface

### rtl/box_strided_point_scanner.sv
// Box strided point scanner: walks a point through a box of up to three dimensions. A load word
// sets the point, a step word adds the x stride with carry into y and z, and each input word
// gives one result word carrying the point and an outside-box flag. A word is held in the input
// register and its result is registered in the point register; a new word is taken every cycle
// unless the result side stalls. The add, compare and select chain over the dimensions is
// combinational between the two registers.
module box_strided_point_scanner
  import bsps_pkg::*;
#(
  parameter int unsigned COORD_WIDTH  = 16,
  parameter int unsigned STRIDE_WIDTH = 8,
  parameter int unsigned DIMENSIONS   = 3
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [((COORD_WIDTH > NUM_COORDS*STRIDE_WIDTH) ? COORD_WIDTH
                 : NUM_COORDS*STRIDE_WIDTH)-1:0] cfg_wdata_i,
  bsps_in_if.sink                 in_i,
  bsps_out_if.source              out_o
);

  localparam int unsigned CFG_DW = (COORD_WIDTH > NUM_COORDS*STRIDE_WIDTH) ? COORD_WIDTH
                                   : NUM_COORDS*STRIDE_WIDTH;

  logic signed [COORD_WIDTH-1:0]        low    [NUM_COORDS];
  logic signed [COORD_WIDTH-1:0]        high   [NUM_COORDS];
  logic [NUM_COORDS*STRIDE_WIDTH-1:0]   strides;

  logic                                 in_valid_q;
  logic                                 op_q;
  logic signed [COORD_WIDTH-1:0]        start_q [NUM_COORDS];
  logic signed [COORD_WIDTH-1:0]        point_q [NUM_COORDS];
  logic signed [COORD_WIDTH-1:0]        point_d [NUM_COORDS];
  logic                                 finished_q;
  logic                                 finished_d;
  logic                                 out_valid_q;
  logic                                 advance;
  logic                                 in_take;

  bsps_cfg #(
    .COORD_WIDTH (COORD_WIDTH),
    .STRIDE_WIDTH(STRIDE_WIDTH),
    .CFG_DW      (CFG_DW)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .low_o      (low),
    .high_o     (high),
    .strides_o  (strides)
  );

  // the word in the input register moves on once the result register is free
  assign advance = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_take = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q       <= in_i.op;
      start_q[0] <= in_i.start_x;
      start_q[1] <= in_i.start_y;
      start_q[2] <= in_i.start_z;
    end
  end

  bsps_step #(
    .COORD_WIDTH (COORD_WIDTH),
    .STRIDE_WIDTH(STRIDE_WIDTH),
    .DIMENSIONS  (DIMENSIONS)
  ) u_step (
    .op_i      (op_q),
    .start_i   (start_q),
    .point_i   (point_q),
    .finished_i(finished_q),
    .low_i     (low),
    .high_i    (high),
    .strides_i (strides),
    .point_o   (point_d),
    .finished_o(finished_d)
  );

  // the point register is both the scan state and the result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < NUM_COORDS; d++) begin
        point_q[d] <= '0;
      end
      finished_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      point_q     <= point_d;
      finished_q  <= finished_d;
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.point_x     = point_q[0];
  assign out_o.point_y     = point_q[1];
  assign out_o.point_z     = point_q[2];
  assign out_o.outside_box = finished_q;

endmodule

### rtl/bsps_cfg.sv
// configuration registers: box corners and packed strides
module bsps_cfg
  import bsps_pkg::*;
#(
  parameter int unsigned COORD_WIDTH  = 16,
  parameter int unsigned STRIDE_WIDTH = 8,
  parameter int unsigned CFG_DW       = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [CFG_IDX_W-1:0]            cfg_idx_i,
  input  logic [CFG_DW-1:0]               cfg_wdata_i,
  output logic signed [COORD_WIDTH-1:0]   low_o    [NUM_COORDS],
  output logic signed [COORD_WIDTH-1:0]   high_o   [NUM_COORDS],
  output logic [NUM_COORDS*STRIDE_WIDTH-1:0] strides_o
);

  localparam int unsigned STRIDE_REG_W = NUM_COORDS * STRIDE_WIDTH;
  localparam logic [STRIDE_WIDTH-1:0] STRIDE_ONE = STRIDE_WIDTH'(1);

  logic signed [COORD_WIDTH-1:0]  low_q  [NUM_COORDS];
  logic signed [COORD_WIDTH-1:0]  high_q [NUM_COORDS];
  logic [STRIDE_REG_W-1:0]        strides_q;
  logic [COORD_WIDTH-1:0]         wcoord;

  assign wcoord = cfg_wdata_i[COORD_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < NUM_COORDS; d++) begin
        low_q[d]  <= '0;
        high_q[d] <= '0;
      end
      strides_q <= {NUM_COORDS{STRIDE_ONE}};
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_BOX_LOW_X:    low_q[0]  <= wcoord;
        REG_BOX_LOW_Y:    low_q[1]  <= wcoord;
        REG_BOX_LOW_Z:    low_q[2]  <= wcoord;
        REG_BOX_HIGH_X:   high_q[0] <= wcoord;
        REG_BOX_HIGH_Y:   high_q[1] <= wcoord;
        REG_BOX_HIGH_Z:   high_q[2] <= wcoord;
        REG_STRIDE_STEPS: strides_q <= cfg_wdata_i[STRIDE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign low_o     = low_q;
  assign high_o    = high_q;
  assign strides_o = strides_q;

endmodule

### rtl/bsps_step.sv
// next point and box test for one load or step word
module bsps_step
  import bsps_pkg::*;
#(
  parameter int unsigned COORD_WIDTH  = 16,
  parameter int unsigned STRIDE_WIDTH = 8,
  parameter int unsigned DIMENSIONS   = 3
) (
  input  logic                                op_i,
  input  logic signed [COORD_WIDTH-1:0]       start_i   [NUM_COORDS],
  input  logic signed [COORD_WIDTH-1:0]       point_i   [NUM_COORDS],
  input  logic                                finished_i,
  input  logic signed [COORD_WIDTH-1:0]       low_i     [NUM_COORDS],
  input  logic signed [COORD_WIDTH-1:0]       high_i    [NUM_COORDS],
  input  logic [NUM_COORDS*STRIDE_WIDTH-1:0]  strides_i,
  output logic signed [COORD_WIDTH-1:0]       point_o   [NUM_COORDS],
  output logic                                finished_o
);

  // wide enough for coordinate plus stride without overflow
  localparam int unsigned AW = ((COORD_WIDTH > STRIDE_WIDTH) ? COORD_WIDTH : STRIDE_WIDTH) + 2;
  localparam logic signed [AW-1:0] COORD_MAX_EXT =
    {{(AW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};

  logic [STRIDE_WIDTH-1:0]        stride [NUM_COORDS];
  logic signed [AW-1:0]           sum    [NUM_COORDS];
  logic signed [AW-1:0]           high_x [NUM_COORDS];
  logic                           carry  [NUM_COORDS+1];
  logic signed [COORD_WIDTH-1:0]  stepped [NUM_COORDS];
  logic signed [COORD_WIDTH-1:0]  next_pt [NUM_COORDS];
  logic                           outside;

  always_comb begin
    carry[0] = 1'b1;
    for (int d = 0; d < NUM_COORDS; d++) begin
      stride[d] = strides_i[d*STRIDE_WIDTH +: STRIDE_WIDTH];
      if (stride[d] == '0) begin
        stride[d] = STRIDE_WIDTH'(1);
      end
      high_x[d] = {{(AW-COORD_WIDTH){high_i[d][COORD_WIDTH-1]}}, high_i[d]};
      sum[d] = {{(AW-COORD_WIDTH){point_i[d][COORD_WIDTH-1]}}, point_i[d]}
             + (carry[d] ? {{(AW-STRIDE_WIDTH){1'b0}}, stride[d]} : '0);
      carry[d+1] = 1'b0;
      stepped[d] = point_i[d];
      if (d + 1 < DIMENSIONS) begin
        // carry into the next dimension when this one passes its high corner
        if (carry[d] && (sum[d] > high_x[d])) begin
          stepped[d]  = low_i[d];
          carry[d+1]  = 1'b1;
        end else begin
          stepped[d] = sum[d][COORD_WIDTH-1:0];
        end
      end else if (d + 1 == DIMENSIONS) begin
        // last active dimension saturates instead of wrapping
        if (sum[d] > COORD_MAX_EXT) begin
          stepped[d] = COORD_MAX_EXT[COORD_WIDTH-1:0];
        end else begin
          stepped[d] = sum[d][COORD_WIDTH-1:0];
        end
      end
    end
  end

  always_comb begin
    for (int d = 0; d < NUM_COORDS; d++) begin
      if (op_e'(op_i) == OP_LOAD) begin
        next_pt[d] = start_i[d];
      end else if (finished_i) begin
        next_pt[d] = point_i[d];
      end else begin
        next_pt[d] = stepped[d];
      end
    end
    outside = 1'b0;
    for (int d = 0; d < DIMENSIONS; d++) begin
      if ((next_pt[d] < low_i[d]) || (next_pt[d] > high_i[d])) begin
        outside = 1'b1;
      end
    end
  end

  assign point_o    = next_pt;
  assign finished_o = ((op_e'(op_i) == OP_STEP) && finished_i) ? 1'b1 : outside;

endmodule

### tb/sv/box_strided_point_scanner_test.sv
`timescale 1ns / 100ps
// self-checking testbench for the box strided point scanner
module box_strided_point_scanner_test;
  import bsps_pkg::*;

  localparam int COORD_W = 16;
  localparam int STRIDE_W = 8;
  localparam int DIMS = 3;
  localparam int CFG_DATA_W = (COORD_W > NUM_COORDS * STRIDE_W) ? COORD_W
                              : NUM_COORDS * STRIDE_W;
  localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;
  localparam int COORD_MIN = -(1 << (COORD_W - 1));
  localparam int SCAN_LATENCY = 2;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PHASES = 24;
  localparam int WORDS_PER_PHASE = 28;
  localparam int QUIET_PHASES = 3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [CFG_DATA_W-1:0] STRIDES_UNIT = 24'h010101;
  localparam logic [CFG_DATA_W-1:0] STRIDES_ZERO = 24'h000000;
  localparam logic [CFG_DATA_W-1:0] STRIDES_FULL = 24'hFFFFFF;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      outside;
  } point_word_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  bsps_in_if #(.COORD_WIDTH(COORD_W)) scan_in ();
  bsps_out_if #(.COORD_WIDTH(COORD_W)) scan_out ();

  box_strided_point_scanner #(
    .COORD_WIDTH (COORD_W),
    .STRIDE_WIDTH(STRIDE_W),
    .DIMENSIONS  (DIMS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (scan_in),
    .out_o      (scan_out)
  );

  // scanner state as predicted
  logic signed [COORD_W-1:0] box_low [NUM_COORDS];
  logic signed [COORD_W-1:0] box_high [NUM_COORDS];
  logic [CFG_DATA_W-1:0]     stride_word;
  int                        scan_point [NUM_COORDS];
  bit                        scan_done;

  point_word_t pending_points [$];

  bit sender_idles = 1'b1;
  bit sink_stalls = 1'b1;
  int loads_sent;
  int steps_sent;
  int outside_seen;
  int config_writes;
  int box_settings;
  int mismatch_count;
  int cycle_count;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int stride_for(int d);
    logic [STRIDE_W-1:0] s;
    s = stride_word[d*STRIDE_W +: STRIDE_W];
    return (s == 0) ? 1 : int'(s);
  endfunction

  function automatic bit point_outside_box();
    int lo;
    int hi;
    for (int d = 0; d < DIMS; d++) begin
      lo = box_low[d];
      hi = box_high[d];
      if (scan_point[d] < lo || scan_point[d] > hi) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic point_word_t advance_scan(op_e op, logic signed [COORD_W-1:0] sx,
                                               logic signed [COORD_W-1:0] sy,
                                               logic signed [COORD_W-1:0] sz);
    point_word_t w;
    int hi;
    if (op == OP_LOAD) begin
      scan_point[0] = sx;
      scan_point[1] = sy;
      scan_point[2] = sz;
      scan_done = point_outside_box();
    end else if (!scan_done) begin
      scan_point[0] += stride_for(0);
      // carry ripples only while a coordinate passes its high corner
      for (int d = 0; d < DIMS - 1; d++) begin
        hi = box_high[d];
        if (scan_point[d] <= hi) break;
        scan_point[d] = box_low[d];
        scan_point[d+1] += stride_for(d + 1);
      end
      if (scan_point[DIMS-1] > COORD_MAX) scan_point[DIMS-1] = COORD_MAX;
      scan_done = point_outside_box();
    end
    w.x = scan_point[0][COORD_W-1:0];
    w.y = scan_point[1][COORD_W-1:0];
    w.z = scan_point[2][COORD_W-1:0];
    w.outside = scan_done;
    return w;
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    return COORD_W'($urandom());
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_start(int d);
    int lo;
    int hi;
    lo = box_low[d];
    hi = box_high[d];
    if (hi < lo || $urandom_range(0, 4) == 0) return COORD_W'($urandom());
    return COORD_W'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  function automatic bit field_matches(string name, logic signed [COORD_W-1:0] want,
                                       logic signed [COORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_BOX_LOW_X, REG_BOX_LOW_Y, REG_BOX_LOW_Z:
        box_low[idx - REG_BOX_LOW_X] = data[COORD_W-1:0];
      REG_BOX_HIGH_X, REG_BOX_HIGH_Y, REG_BOX_HIGH_Z:
        box_high[idx - REG_BOX_HIGH_X] = data[COORD_W-1:0];
      REG_STRIDE_STEPS: stride_word = data;
      default: ;  // unmapped index is dropped
    endcase
    config_writes++;
    @(posedge clk_i);
  endtask

  task automatic program_box(int lx, int ly, int lz, int hx, int hy, int hz,
                             logic [CFG_DATA_W-1:0] strides);
    write_reg(REG_BOX_LOW_X, CFG_DATA_W'(lx));
    write_reg(REG_BOX_LOW_Y, CFG_DATA_W'(ly));
    write_reg(REG_BOX_LOW_Z, CFG_DATA_W'(lz));
    write_reg(REG_BOX_HIGH_X, CFG_DATA_W'(hx));
    write_reg(REG_BOX_HIGH_Y, CFG_DATA_W'(hy));
    write_reg(REG_BOX_HIGH_Z, CFG_DATA_W'(hz));
    write_reg(REG_STRIDE_STEPS, strides);
    box_settings++;
  endtask

  task automatic send_word(op_e op, logic signed [COORD_W-1:0] sx,
                           logic signed [COORD_W-1:0] sy, logic signed [COORD_W-1:0] sz);
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      scan_in.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    scan_in.valid <= 1'b1;
    scan_in.op <= op;
    scan_in.start_x <= sx;
    scan_in.start_y <= sy;
    scan_in.start_z <= sz;
    @(posedge clk_i);
    while (!scan_in.ready) @(posedge clk_i);
    pending_points.push_back(advance_scan(op, sx, sy, sz));
    if (op == OP_LOAD) loads_sent++;
    else steps_sent++;
  endtask

  task automatic wait_for_results();
    scan_in.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (SCAN_LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic test_reset_values();
    // reset box is the single origin point with unit strides
    send_word(OP_STEP, rand_coord(), rand_coord(), rand_coord());
    send_word(OP_STEP, 0, 0, 0);
    send_word(OP_LOAD, 0, 0, 0);
    wait_for_results();
  endtask

  task automatic test_small_box_scan();
    // x stride two, y stride field zero acting as one, z stride one
    program_box(-2, -1, 5, 1, 0, 6, {8'd1, 8'd0, 8'd2});
    send_word(OP_LOAD, -2, -1, 5);
    repeat (9) send_word(OP_STEP, rand_coord(), rand_coord(), rand_coord());
    send_word(OP_LOAD, 2, 0, 5);
    send_word(OP_LOAD, 0, -2, 6);
    wait_for_results();
  endtask

  task automatic test_coordinate_extremes();
    program_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                STRIDES_FULL);
    send_word(OP_LOAD, COORD_MAX, COORD_MAX, COORD_MAX);
    send_word(OP_STEP, 0, 0, 0);
    send_word(OP_LOAD, COORD_MIN, COORD_MIN, COORD_MIN);
    send_word(OP_STEP, -1, -1, -1);
    wait_for_results();
    // low above high in x makes the box empty
    program_box(5, COORD_MIN, COORD_MIN, 4, COORD_MAX, COORD_MAX, STRIDES_ZERO);
    send_word(OP_LOAD, 5, 0, 0);
    send_word(OP_STEP, 0, 0, 0);
    wait_for_results();
  endtask

  task automatic test_config_without_recompute();
    program_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                STRIDES_UNIT);
    send_word(OP_LOAD, 0, 0, 0);
    wait_for_results();
    // point now sits past the high corner but the flag stays clear
    write_reg(REG_BOX_HIGH_X, CFG_DATA_W'(-1));
    write_reg(REG_UNUSED, 24'h5A5A5A);
    send_word(OP_STEP, 0, 0, 0);
    wait_for_results();
  endtask

  task automatic program_random_box();
    int lo [NUM_COORDS];
    int hi [NUM_COORDS];
    int shape;
    int base;
    int width;
    logic [CFG_DATA_W-1:0] strides;
    for (int d = 0; d < NUM_COORDS; d++) begin
      shape = $urandom_range(0, 15);
      base = int'($urandom_range(0, 65535)) + COORD_MIN;
      width = $urandom_range(0, 7);
      case (shape)
        0: begin
          lo[d] = COORD_MIN;
          hi[d] = COORD_MAX;
        end
        1: begin
          lo[d] = (base == COORD_MIN) ? base + 1 : base;
          hi[d] = lo[d] - 1;
        end
        2, 3: begin
          hi[d] = COORD_MAX;
          lo[d] = COORD_MAX - width;
        end
        default: begin
          lo[d] = base;
          hi[d] = (base + width > COORD_MAX) ? COORD_MAX : base + width;
        end
      endcase
    end
    case ($urandom_range(0, 7))
      0: strides = STRIDES_ZERO;
      1: strides = STRIDES_FULL;
      2: strides = CFG_DATA_W'($urandom());
      default: begin
        for (int d = 0; d < NUM_COORDS; d++)
          strides[d*STRIDE_W +: STRIDE_W] = STRIDE_W'($urandom_range(0, 3));
      end
    endcase
    program_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], strides);
  endtask

  task automatic test_random_scans();
    int sent;
    int run;
    int pick;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase >= RANDOM_PHASES - QUIET_PHASES) begin
        sender_idles = 1'b0;
        sink_stalls = 1'b0;
      end
      program_random_box();
      sent = 0;
      while (sent < WORDS_PER_PHASE) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          send_word(OP_LOAD, rand_coord(), rand_coord(), rand_coord());
          sent++;
        end else if (pick == 1) begin
          // steps with no fresh load in front
          run = $urandom_range(1, 3);
          repeat (run) send_word(OP_STEP, rand_coord(), rand_coord(), rand_coord());
          sent += run;
        end else begin
          send_word(OP_LOAD, pick_start(0), pick_start(1), pick_start(2));
          run = $urandom_range(1, 40);
          repeat (run) send_word(OP_STEP, rand_coord(), rand_coord(), rand_coord());
          sent += run + 1;
        end
      end
      wait_for_results();
    end
  endtask

  // result side stalls in short bursts
  initial begin
    scan_out.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_stalls && $urandom_range(0, 5) == 0) begin
        scan_out.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
      scan_out.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    point_word_t want;
    if (rst_ni && scan_out.valid && scan_out.ready) begin
      if (pending_points.size() == 0) begin
        $display("%0t: result word with none expected: x %0d y %0d z %0d outside %0b",
                 $time, scan_out.point_x, scan_out.point_y, scan_out.point_z,
                 scan_out.outside_box);
        mismatch_count++;
      end else begin
        want = pending_points.pop_front();
        if (!field_matches("point_x", want.x, scan_out.point_x)) mismatch_count++;
        if (!field_matches("point_y", want.y, scan_out.point_y)) mismatch_count++;
        if (!field_matches("point_z", want.z, scan_out.point_z)) mismatch_count++;
        if (!field_matches("outside_box", COORD_W'(want.outside),
                           COORD_W'(scan_out.outside_box)))
          mismatch_count++;
        if (scan_out.outside_box === 1'b1) outside_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d words outstanding", cycle_count,
               pending_points.size());
      $display("box_strided_point_scanner_test: FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_BOX_LOW_X;
    cfg_wdata_i = '0;
    scan_in.valid = 1'b0;
    scan_in.op = OP_LOAD;
    scan_in.start_x = '0;
    scan_in.start_y = '0;
    scan_in.start_z = '0;
    for (int d = 0; d < NUM_COORDS; d++) begin
      box_low[d] = '0;
      box_high[d] = '0;
      scan_point[d] = 0;
    end
    stride_word = STRIDES_UNIT;
    scan_done = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_small_box_scan();
    test_coordinate_extremes();
    test_config_without_recompute();
    test_random_scans();

    $display("scanned %0d load and %0d step words over %0d box settings (%0d register writes)",
             loads_sent, steps_sent, box_settings, config_writes);
    $display("%0d results reported the point outside the box, %0d mismatches",
             outside_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("box_strided_point_scanner_test: PASS");
    end else begin
      $display("box_strided_point_scanner_test: FAIL");
    end
    $finish;
  end

endmodule

### box_strided_point_scanner.f
rtl/bsps_pkg.sv
rtl/bsps_in_if.sv
rtl/bsps_cfg.sv
rtl/bsps_step.sv
rtl/box_strided_point_scanner.sv
tb/sv/box_strided_point_scanner_test.sv
